>>> rtl/rwc_pkg.sv
`default_nettype none
package rwc_pkg;

  // kernel geometry and color layout
  localparam int KSZ = 3;
  localparam int NCH = 3;
  localparam int CH_W = 8;

  // configuration register widths and reset values
  localparam int WIDTH_W = 11;
  localparam int HEIGHT_W = 13;
  localparam int ROW_W = 12;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_SIZE = 3;
  localparam int WIDTH_RESET = 640;
  localparam int HEIGHT_RESET = 480;

  // register indexes of the configuration port
  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_index_t;
  localparam cfg_index_t CFG_IMAGE_WIDTH = 3'd0;
  localparam cfg_index_t CFG_IMAGE_HEIGHT = 3'd1;
  localparam cfg_index_t CFG_COEF_ROW_TOP = 3'd2;
  localparam cfg_index_t CFG_COEF_ROW_MID = 3'd3;
  localparam cfg_index_t CFG_COEF_ROW_BOT = 3'd4;

  // output queue
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // channel 0 is red, 1 green, 2 blue
  typedef logic [NCH-1:0][CH_W-1:0] pixel_t;
  // row 0 is the oldest line
  typedef logic [KSZ-1:0][NCH-1:0][CH_W-1:0] column_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic last;
  } beat_t;

endpackage
`default_nettype wire

>>> rtl/rgb_window_convolution_top.sv
// throughput: one pixel beat per cycle in, one filtered beat per cycle out;
// the output holds while out_stall is high, and the input stalls only when
// the 8-entry output queue plus beats in flight fill up
// reset: counters, pipeline valids and queue clear; geometry returns to 640x480,
// kernel taps to zero; line stores are not cleared and hold nothing until written
`default_nettype none
module rgb_window_convolution_top #(
  parameter int MAX_WIDTH = 1024,
  parameter int COEF_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  // configuration
  input  wire logic cfg_write,
  input  wire rwc_pkg::cfg_index_t cfg_index,
  input  wire logic [3*COEF_BITS-1:0] cfg_data,
  // pixel input
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [7:0] red_in,
  input  wire logic [7:0] green_in,
  input  wire logic [7:0] blue_in,
  // filtered output
  output logic out_valid,
  input  wire logic out_stall,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic frame_last
);

  localparam int KSZ = rwc_pkg::KSZ;
  localparam int NCH = rwc_pkg::NCH;
  localparam int ROW_BITS = KSZ * COEF_BITS;
  localparam int AW = $clog2(MAX_WIDTH);
  // wide enough for the width register and for MAX_WIDTH itself
  localparam int CW = ($clog2(MAX_WIDTH) + 1 > rwc_pkg::WIDTH_W) ?
                      $clog2(MAX_WIDTH) + 1 : rwc_pkg::WIDTH_W;
  localparam int FRAC = COEF_BITS - 2;
  localparam int PW = COEF_BITS + 9;   // one product
  localparam int SW = PW + 2;          // one column sum
  localparam int TW = PW + 4;          // full window sum
  localparam logic signed [TW-1:0] ROUND_VAL = TW'(2 ** (FRAC - 1));
  localparam int CNT_W = rwc_pkg::OUT_CNT_W;

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  logic [rwc_pkg::WIDTH_W-1:0] image_width;
  logic [rwc_pkg::HEIGHT_W-1:0] image_height;
  logic [ROW_BITS-1:0] coef_row_top;
  logic [ROW_BITS-1:0] coef_row_mid;
  logic [ROW_BITS-1:0] coef_row_bot;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= rwc_pkg::WIDTH_W'(rwc_pkg::WIDTH_RESET);
      image_height <= rwc_pkg::HEIGHT_W'(rwc_pkg::HEIGHT_RESET);
      coef_row_top <= '0;
      coef_row_mid <= '0;
      coef_row_bot <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        rwc_pkg::CFG_IMAGE_WIDTH: image_width <= cfg_data[rwc_pkg::WIDTH_W-1:0];
        rwc_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data[rwc_pkg::HEIGHT_W-1:0];
        rwc_pkg::CFG_COEF_ROW_TOP: coef_row_top <= cfg_data;
        rwc_pkg::CFG_COEF_ROW_MID: coef_row_mid <= cfg_data;
        rwc_pkg::CFG_COEF_ROW_BOT: coef_row_bot <= cfg_data;
        default: ;
      endcase
    end
  end

  // width clamped to 3..MAX_WIDTH, the line store depth; height to 3..MAX_HEIGHT
  logic [CW-1:0] width_eff;
  logic [rwc_pkg::HEIGHT_W-1:0] height_eff;

  always_comb begin
    if (CW'(image_width) < CW'(rwc_pkg::MIN_SIZE)) begin
      width_eff = CW'(rwc_pkg::MIN_SIZE);
    end else if (CW'(image_width) > CW'(MAX_WIDTH)) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = CW'(image_width);
    end
    if (image_height < rwc_pkg::HEIGHT_W'(rwc_pkg::MIN_SIZE)) begin
      height_eff = rwc_pkg::HEIGHT_W'(rwc_pkg::MIN_SIZE);
    end else if (image_height > rwc_pkg::HEIGHT_W'(rwc_pkg::MAX_HEIGHT)) begin
      height_eff = rwc_pkg::HEIGHT_W'(rwc_pkg::MAX_HEIGHT);
    end else begin
      height_eff = image_height;
    end
  end

  // ------------------------------------------------------------------
  // raster position of the next pixel
  // ------------------------------------------------------------------
  logic accept;
  logic [AW-1:0] column_count;
  logic [rwc_pkg::ROW_W-1:0] row_count;
  logic row_end;
  logic frame_end;
  logic emit;

  assign accept = in_valid && !in_stall;
  assign row_end = (CW'(column_count) + 1'b1) >= width_eff;
  assign frame_end = row_end &&
                     ((rwc_pkg::HEIGHT_W'(row_count) + 1'b1) >= height_eff);
  // a full window exists once two columns and two rows are behind us
  assign emit = (column_count >= AW'(KSZ - 1)) &&
                (row_count >= rwc_pkg::ROW_W'(KSZ - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (row_end) begin
        column_count <= '0;
        row_count <= frame_end ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // stage 1: line store read, newer store written with the new pixel
  // stage 2 writes the older store from the newer read data, so each store
  // sees one read and one write per cycle
  // ------------------------------------------------------------------
  rwc_pkg::pixel_t line_store_older [MAX_WIDTH];
  rwc_pkg::pixel_t line_store_newer [MAX_WIDTH];
  rwc_pkg::pixel_t pix_in;
  rwc_pkg::pixel_t pix1;
  rwc_pkg::pixel_t rd_old;
  rwc_pkg::pixel_t rd_new;
  logic [AW-1:0] col1;
  logic v1;
  logic e1;
  logic last1;

  assign pix_in = {blue_in, green_in, red_in};

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_old <= line_store_older[column_count];
      rd_new <= line_store_newer[column_count];
      line_store_newer[column_count] <= pix_in;
    end
    if (v1) begin
      line_store_older[col1] <= rd_new;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix1 <= pix_in;
      col1 <= column_count;
      last1 <= frame_end;
    end
  end

  // ------------------------------------------------------------------
  // stages 2..4: chain of window cells; the new column enters at the right
  // cell, the left cell holds the oldest column. each cell registers its
  // nine products, then its three column sums
  // ------------------------------------------------------------------
  rwc_pkg::column_t new_column;
  rwc_pkg::column_t chain [KSZ+1];
  logic [NCH-1:0][SW-1:0] col_sum [KSZ];
  logic [KSZ-1:0][COEF_BITS-1:0] cell_taps [KSZ];

  assign new_column = {pix1, rd_new, rd_old};
  assign chain[KSZ] = new_column;

  for (genvar k = 0; k < KSZ; k++) begin : g_cell
    assign cell_taps[k] = {coef_row_bot[k*COEF_BITS +: COEF_BITS],
                           coef_row_mid[k*COEF_BITS +: COEF_BITS],
                           coef_row_top[k*COEF_BITS +: COEF_BITS]};

    rwc_cell #(
      .COEF_BITS(COEF_BITS)
    ) u_cell (
      .clk(clk),
      .shift(v1),
      .col_in(chain[k+1]),
      .taps(cell_taps[k]),
      .col_out(chain[k]),
      .col_sum(col_sum[k])
    );
  end

  // ------------------------------------------------------------------
  // stage 5: window sum plus rounding half, stage 6 saturate into queue
  // ------------------------------------------------------------------
  logic signed [TW-1:0] total [NCH];

  always_ff @(posedge clk) begin
    for (int c = 0; c < NCH; c++) begin
      total[c] <= TW'($signed(col_sum[0][c])) + TW'($signed(col_sum[1][c])) +
                  TW'($signed(col_sum[2][c])) + ROUND_VAL;
    end
  end

  function automatic logic [7:0] saturate(input logic signed [TW-1:0] t);
    logic [7:0] res;
    if (t[TW-1]) begin
      res = 8'd0;
    end else if (|t[TW-2:FRAC+8]) begin
      res = 8'hff;
    end else begin
      res = t[FRAC+7:FRAC];
    end
    return res;
  endfunction

  // ------------------------------------------------------------------
  // beat tracking through the pipe; only window positions go past stage 1
  // ------------------------------------------------------------------
  logic e2;
  logic e3;
  logic e4;
  logic e5;
  logic last2;
  logic last3;
  logic last4;
  logic last5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      e1 <= 1'b0;
      e2 <= 1'b0;
      e3 <= 1'b0;
      e4 <= 1'b0;
      e5 <= 1'b0;
    end else begin
      v1 <= accept;
      e1 <= accept && emit;
      e2 <= v1 && e1;
      e3 <= e2;
      e4 <= e3;
      e5 <= e4;
    end
  end

  always_ff @(posedge clk) begin
    last2 <= last1;
    last3 <= last2;
    last4 <= last3;
    last5 <= last4;
  end

  // ------------------------------------------------------------------
  // output queue; every result in flight has a slot reserved
  // ------------------------------------------------------------------
  rwc_pkg::beat_t push_data;
  rwc_pkg::beat_t head;
  logic [CNT_W-1:0] fifo_count;
  logic [CNT_W-1:0] pending;
  logic pop;

  assign push_data.red = saturate(total[0]);
  assign push_data.green = saturate(total[1]);
  assign push_data.blue = saturate(total[2]);
  assign push_data.last = last5;

  assign pop = out_valid && !out_stall;

  rwc_out_fifo u_out_fifo (
    .clk(clk),
    .rst(rst),
    .push(e5),
    .push_data(push_data),
    .pop(pop),
    .head(head),
    .count(fifo_count)
  );

  assign pending = fifo_count + CNT_W'(e1 && v1) + CNT_W'(e2) + CNT_W'(e3) +
                   CNT_W'(e4) + CNT_W'(e5);
  assign in_stall = pending >= CNT_W'(rwc_pkg::OUT_DEPTH);

  assign out_valid = fifo_count != '0;
  assign red_out = head.red;
  assign green_out = head.green;
  assign blue_out = head.blue;
  assign frame_last = head.last;

endmodule
`default_nettype wire

>>> rtl/rwc_cell.sv
`default_nettype none
module rwc_cell #(
  parameter int COEF_BITS = 16
) (
  input  wire logic clk,
  input  wire logic shift,
  input  wire rwc_pkg::column_t col_in,
  input  wire logic [rwc_pkg::KSZ-1:0][COEF_BITS-1:0] taps,
  output rwc_pkg::column_t col_out,
  output logic [rwc_pkg::NCH-1:0][COEF_BITS+10:0] col_sum
);

  localparam int PW = COEF_BITS + 9;
  localparam int SW = PW + 2;

  rwc_pkg::column_t col_q;
  logic signed [PW-1:0] prod [rwc_pkg::KSZ][rwc_pkg::NCH];

  // window column, moves one cell left per pixel beat
  always_ff @(posedge clk) begin
    if (shift) begin
      col_q <= col_in;
    end
  end

  // one tap per row, all channels
  always_ff @(posedge clk) begin
    for (int r = 0; r < rwc_pkg::KSZ; r++) begin
      for (int c = 0; c < rwc_pkg::NCH; c++) begin
        prod[r][c] <= $signed({1'b0, col_q[r][c]}) * $signed(taps[r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < rwc_pkg::NCH; c++) begin
      col_sum[c] <= SW'(prod[0][c]) + SW'(prod[1][c]) + SW'(prod[2][c]);
    end
  end

  assign col_out = col_q;

endmodule
`default_nettype wire

>>> rtl/rwc_out_fifo.sv
`default_nettype none
module rwc_out_fifo (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire rwc_pkg::beat_t push_data,
  input  wire logic pop,
  output rwc_pkg::beat_t head,
  output logic [rwc_pkg::OUT_CNT_W-1:0] count
);

  rwc_pkg::beat_t mem [rwc_pkg::OUT_DEPTH];
  logic [rwc_pkg::OUT_PTR_W-1:0] wr_ptr;
  logic [rwc_pkg::OUT_PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head = mem[rd_ptr];

endmodule
`default_nettype wire
